// File: rtl/assert_macros.svh
// Assertion macros shared by the frame decoder RTL.
// Expects signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HTFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame decoder assertion failed");

// Next-cycle implication, disabled during reset.
`define HTFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame decoder assertion failed");

`endif

// File: rtl/htfd_pkg.sv
// Package for the humidity/temperature frame decoder: types, constants, CRC-8 step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htfd_pkg;

    localparam int PROD_W = 27;

    localparam logic [7:0]        CRC_INIT        = 8'hFF;
    localparam logic [7:0]        CRC_POLY        = 8'h31;
    localparam logic [10:0]       TEMP_SCALE      = 11'd1750;
    localparam logic [10:0]       HUMI_SCALE      = 11'd1000;
    localparam logic [PROD_W-1:0] TEMP_OFFSET_NUM = 27'd29490750;
    localparam logic signed [11:0] TEMP_OFFSET    = 12'sd450;
    localparam logic signed [11:0] TEMP_MIN       = -12'sd450;
    localparam logic signed [11:0] TEMP_MAX       = 12'sd1300;
    localparam logic [9:0]        HUMI_MAX        = 10'd1000;

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TEMP_FAIL = 2'd1,
        STATUS_HUMI_FAIL = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [11:0] temp_tenths;
        logic [9:0]         humi_tenths;
    } conv_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/htfd_convert.sv
// Scaled-product to tenths conversion: divide by full scale, offset temperature.
// Depends on htfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htfd_convert (
    input  wire logic [htfd_pkg::PROD_W-1:0] product,
    output htfd_pkg::conv_t                  conv
);
    import htfd_pkg::*;

    logic [PROD_W:0]    sum;
    logic [10:0]        quot;
    logic [PROD_W-1:0]  back;
    logic               rem_nz;
    logic               neg;
    logic signed [11:0] quot_s;

    always_comb
    begin
        // floor(t / 65535) = (t + (t >> 16) + 1) >> 16 over this range
        sum    = {1'b0, product} + (PROD_W+1)'(product >> 16) + (PROD_W+1)'(1);
        quot   = sum[PROD_W-1:16];
        back   = {quot, 16'b0} - PROD_W'(quot);
        rem_nz = (product != back);
        neg    = (product < TEMP_OFFSET_NUM);
        quot_s = signed'(12'(quot));
        // truncate toward zero for negative results
        conv.temp_tenths = quot_s - TEMP_OFFSET + ((neg && rem_nz) ? 12'sd1 : 12'sd0);
        conv.humi_tenths = quot[9:0];
    end

endmodule

`default_nettype wire

// File: rtl/humidity_temp_frame_decoder_top.sv
// The result is presented in the cycle after the sixth beat of a reply is accepted.
// Throughput: one input beat per cycle; input stalls only while a result is held and
// the output is stalled (single output register between the two sides).
// Conversion runs off a product registered on the low data byte, finished on the CRC byte.
// Reset: all but the output payload clears; byte position returns to the first byte.
// Depends on htfd_pkg, htfd_convert and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module humidity_temp_frame_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic signed [11:0] temperature_tenths,
    output logic [9:0]       humidity_tenths
);
    import htfd_pkg::*;

    pos_t               pos_reg, pos_next, pos_cur;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         hold_reg, hold_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               temp_failed_reg, temp_failed_next;
    logic signed [11:0] saved_temp_reg, saved_temp_next;
    logic [9:0]         saved_humi_reg, saved_humi_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic signed [11:0] out_temp_reg;
    logic [9:0]         out_humi_reg;

    logic               accept;
    logic               emit;
    logic               crc_match;
    logic [10:0]        scale;
    conv_t              conv;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign pos_cur  = frame_start ? POS_T_HI : pos_reg;
    assign crc_match = (crc_reg == data_byte);

    htfd_convert u_convert (
        .product (prod_reg),
        .conv    (conv)
    );

    // next byte position
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            case (pos_cur)
                POS_T_HI:  pos_next = POS_T_LO;
                POS_T_LO:  pos_next = POS_T_CRC;
                POS_T_CRC: pos_next = POS_H_HI;
                POS_H_HI:  pos_next = POS_H_LO;
                POS_H_LO:  pos_next = POS_H_CRC;
                default:   pos_next = POS_T_HI;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        crc_next         = crc_reg;
        hold_next        = hold_reg;
        prod_next        = prod_reg;
        temp_failed_next = temp_failed_reg;
        saved_temp_next  = saved_temp_reg;
        saved_humi_next  = saved_humi_reg;
        status_next      = status_reg;
        emit             = 1'b0;
        scale            = (pos_cur == POS_T_LO) ? TEMP_SCALE : HUMI_SCALE;
        if (accept)
        begin
            case (pos_cur)
                POS_T_HI, POS_H_HI:
                begin
                    crc_next  = crc_feed(CRC_INIT, data_byte);
                    hold_next = data_byte;
                end
                POS_T_LO, POS_H_LO:
                begin
                    crc_next  = crc_feed(crc_reg, data_byte);
                    prod_next = PROD_W'({hold_reg, data_byte}) * PROD_W'(scale);
                end
                POS_T_CRC:
                begin
                    temp_failed_next = !crc_match;
                    if (crc_match)
                    begin
                        saved_temp_next = conv.temp_tenths;
                    end
                end
                default:
                begin
                    emit = 1'b1;
                    if (temp_failed_reg)
                    begin
                        status_next = STATUS_TEMP_FAIL;
                    end
                    else if (!crc_match)
                    begin
                        status_next = STATUS_HUMI_FAIL;
                    end
                    else
                    begin
                        status_next     = STATUS_OK;
                        saved_humi_next = conv.humi_tenths;
                    end
                end
            endcase
        end
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_T_HI;
            crc_reg         <= CRC_INIT;
            hold_reg        <= '0;
            prod_reg        <= '0;
            temp_failed_reg <= 1'b0;
            saved_temp_reg  <= '0;
            saved_humi_reg  <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= STATUS_OK;
        end
        else
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            hold_reg        <= hold_next;
            prod_reg        <= prod_next;
            temp_failed_reg <= temp_failed_next;
            saved_temp_reg  <= saved_temp_next;
            saved_humi_reg  <= saved_humi_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
        end
    end

    // hold result payload until a new one is emitted
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_temp_reg <= saved_temp_next;
            out_humi_reg <= saved_humi_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign temperature_tenths = out_temp_reg;
    assign humidity_tenths    = out_humi_reg;

    `HTFD_ASSERT_NEXT(a_last_beat_emits, accept && !frame_start && pos_reg == POS_H_CRC, out_valid)
    `HTFD_ASSERT_NEXT(a_start_advances, accept && frame_start, pos_reg == POS_T_LO)
    `HTFD_ASSERT_IMPL(a_ranges, out_valid,
        temperature_tenths >= TEMP_MIN && temperature_tenths <= TEMP_MAX
        && humidity_tenths <= HUMI_MAX)

endmodule

`default_nettype wire

// File: tb/tb_humidity_temp_frame_decoder_top.sv
// Self-checking bench for humidity_temp_frame_decoder_top: queue-fed byte driver, output monitor,
// bit-accurate frame decoder predictor with CRC-8 checks and fixed-point conversions.
// Depends on htfd_pkg (pos_t, status_t and their enum values) and the decoder RTL.
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder_top;

    import htfd_pkg::pos_t;
    import htfd_pkg::status_t;
    import htfd_pkg::POS_T_HI;
    import htfd_pkg::POS_T_LO;
    import htfd_pkg::POS_T_CRC;
    import htfd_pkg::POS_H_HI;
    import htfd_pkg::POS_H_LO;
    import htfd_pkg::POS_H_CRC;
    import htfd_pkg::STATUS_OK;
    import htfd_pkg::STATUS_TEMP_FAIL;
    import htfd_pkg::STATUS_HUMI_FAIL;

    localparam logic [7:0] CRC_SEED    = 8'hFF;
    localparam logic [7:0] CRC_GEN     = 8'h31;
    localparam longint     FULL_SCALE  = 65535;
    localparam int         BEAT_TARGET = 1250;
    localparam int         HOLD_CYCLES = 400;
    localparam int         CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        RX_FREE    = 2'd0,
        RX_COIN    = 2'd1,
        RX_HEAVY   = 2'd2,
        RX_PATTERN = 2'd3
    } rx_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } beat_t;

    typedef struct packed {
        status_t            st;
        logic signed [11:0] temp;
        logic [9:0]         humi;
    } reading_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic signed [11:0] temperature_tenths;
    logic [9:0]         humidity_tenths;

    beat_t    pending_beats[$];
    reading_t expected_readings[$];
    beat_t    next_beat;

    pos_t               frame_pos = POS_T_HI;
    logic [7:0]         crc_acc = CRC_SEED;
    logic [7:0]         hi_hold = 8'h00;
    logic [15:0]        word_acc = 16'h0000;
    logic               temp_bad = 1'b0;
    logic signed [11:0] temp_store = 12'sd0;
    logic [9:0]         humi_store = 10'd0;

    int       total_beats = 0;
    int       beats_accepted = 0;
    int       readings_checked = 0;
    int       error_count = 0;
    int       status_seen[4];
    int       gap_left = 0;
    int       burst_left = 0;
    int       hold_left = 0;
    int       holds_done = 0;
    int       mode_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       cycle_count = 0;
    int       in_stall_cycles = 0;

    humidity_temp_frame_decoder_top u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .data_byte          (data_byte),
        .frame_start        (frame_start),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .temperature_tenths (temperature_tenths),
        .humidity_tenths    (humidity_tenths)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_GEN : 8'h00);
        end
        return c;
    endfunction

    function automatic logic signed [11:0] temp_from_raw(input logic [15:0] raw);
        longint num;
        longint q;
        num = 1750 * longint'(raw) - 450 * FULL_SCALE;
        q   = num / FULL_SCALE;
        return q[11:0];
    endfunction

    function automatic logic [9:0] humi_from_raw(input logic [15:0] raw);
        longint q;
        q = (1000 * longint'(raw)) / FULL_SCALE;
        return q[9:0];
    endfunction

    task automatic decode_beat(input logic [7:0] b, input logic start);
        reading_t r;
        if (start)
        begin
            frame_pos = POS_T_HI;
        end
        case (frame_pos)
            POS_T_HI, POS_H_HI:
            begin
                crc_acc   = crc8_step(CRC_SEED, b);
                hi_hold   = b;
                frame_pos = pos_t'(frame_pos + 3'd1);
            end
            POS_T_LO, POS_H_LO:
            begin
                crc_acc   = crc8_step(crc_acc, b);
                word_acc  = {hi_hold, b};
                frame_pos = pos_t'(frame_pos + 3'd1);
            end
            POS_T_CRC:
            begin
                if (crc_acc == b)
                begin
                    temp_bad   = 1'b0;
                    temp_store = temp_from_raw(word_acc);
                end
                else
                begin
                    temp_bad = 1'b1;
                end
                frame_pos = POS_H_HI;
            end
            POS_H_CRC:
            begin
                if (temp_bad)
                begin
                    r.st = STATUS_TEMP_FAIL;
                end
                else if (crc_acc != b)
                begin
                    r.st = STATUS_HUMI_FAIL;
                end
                else
                begin
                    humi_store = humi_from_raw(word_acc);
                    r.st = STATUS_OK;
                end
                r.temp = temp_store;
                r.humi = humi_store;
                expected_readings.push_back(r);
                frame_pos = POS_T_HI;
            end
            default:
            begin
                frame_pos = POS_T_HI;
            end
        endcase
    endtask

    task automatic push_beat(input logic [7:0] b, input logic s);
        beat_t bt;
        bt.data  = b;
        bt.start = s;
        pending_beats.push_back(bt);
    endtask

    // Push the first len bytes of a reply; flips corrupt the CRC bytes.
    task automatic add_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                             input logic mark, input logic [7:0] t_flip,
                             input logic [7:0] h_flip, input int len);
        logic [7:0] fb[6];
        fb[0] = t_raw[15:8];
        fb[1] = t_raw[7:0];
        fb[2] = crc8_step(crc8_step(CRC_SEED, fb[0]), fb[1]) ^ t_flip;
        fb[3] = h_raw[15:8];
        fb[4] = h_raw[7:0];
        fb[5] = crc8_step(crc8_step(CRC_SEED, fb[3]), fb[4]) ^ h_flip;
        for (int i = 0; i < len; i++)
        begin
            push_beat(fb[i], (i == 0) ? mark : 1'b0);
        end
    endtask

    function automatic logic [15:0] raw_pick();
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            3:       return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: bursts of beats with random gaps; hold payload while stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_beat(data_byte, frame_start);
                beats_accepted <= beats_accepted + 1;
            end
            if (in_valid && in_stall)
            begin
                in_valid <= 1'b1;
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                next_beat = pending_beats.pop_front();
                data_byte   <= next_beat.data;
                frame_start <= next_beat.start;
                in_valid    <= 1'b1;
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        burst_left <= $urandom_range(50, 150);
                        gap_left   <= 0;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                                  : $urandom_range(0, 5);
                    end
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: long hold-offs at two points, otherwise a changing pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_done < 2 && beats_accepted >= 300 + 500 * holds_done)
        begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 96);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:    out_stall <= 1'b0;
                RX_COIN:    out_stall <= ($urandom_range(0, 1) == 1);
                RX_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: out_stall <= mode_left[1];
                default:    out_stall <= 1'b0;
            endcase
        end
    end

    // Monitor: compare each accepted reading with the oldest prediction.
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected reading status=%0d temp=%0d humi=%0d", $time,
                         status, temperature_tenths, humidity_tenths);
                error_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    error_count++;
                end
                if (temperature_tenths !== want.temp)
                begin
                    $display("%0t: temperature_tenths expected %0d actual %0d", $time,
                             want.temp, temperature_tenths);
                    error_count++;
                end
                if (humidity_tenths !== want.humi)
                begin
                    $display("%0t: humidity_tenths expected %0d actual %0d", $time,
                             want.humi, humidity_tenths);
                    error_count++;
                end
                readings_checked++;
                status_seen[status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && in_stall)
        begin
            in_stall_cycles++;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d of %0d beats accepted, %0d readings outstanding",
                     $time, beats_accepted, total_beats, expected_readings.size());
            $display("[humidity_temp_frame_decoder_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int  kind;
        int  len;
        logic broken;
        for (int i = 0; i < 4; i++)
        begin
            status_seen[i] = 0;
        end

        add_frame(16'h0000, 16'h0000, 1'b1, 8'h00, 8'h00, 6);
        add_frame(16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 8'h00, 6);
        add_frame(16'h8000, 16'h4000, 1'b1, 8'h00, 8'h00, 2);
        add_frame(16'h6666, 16'h1234, 1'b1, 8'h00, 8'h00, 3);
        add_frame(16'h2000, 16'h8000, 1'b1, 8'h01, 8'h00, 6);
        add_frame(16'h4CCD, 16'hC000, 1'b0, 8'h00, 8'h80, 6);

        broken = 1'b0;
        while (pending_beats.size() < BEAT_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                add_frame(raw_pick(), raw_pick(), broken | 1'($urandom_range(0, 1)),
                          8'h00, 8'h00, 6);
                broken = 1'b0;
            end
            else if (kind < 80)
            begin
                add_frame(raw_pick(), raw_pick(), broken | 1'($urandom_range(0, 1)),
                          8'($urandom_range(1, 255)), 8'($urandom_range(0, 1) * $urandom), 6);
                broken = 1'b0;
            end
            else if (kind < 88)
            begin
                add_frame(raw_pick(), raw_pick(), broken | 1'($urandom_range(0, 1)),
                          8'h00, 8'($urandom_range(1, 255)), 6);
                broken = 1'b0;
            end
            else if (kind < 94)
            begin
                add_frame(raw_pick(), raw_pick(), 1'b1, 8'h00, 8'h00, $urandom_range(1, 5));
                broken = 1'b1;
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    push_beat(8'($urandom), 1'($urandom_range(0, 1)));
                end
                broken = 1'b1;
            end
        end
        total_beats = pending_beats.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_accepted < total_beats)
        begin
            @(posedge clk);
        end
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (expected_readings.size() != 0)
        begin
            $display("%0t: %0d predicted readings never arrived", $time,
                     expected_readings.size());
            error_count++;
        end
        $display("Covered %0d beats and %0d readings: %0d ok, %0d temp crc fail, %0d humi crc fail",
                 beats_accepted, readings_checked, status_seen[STATUS_OK],
                 status_seen[STATUS_TEMP_FAIL], status_seen[STATUS_HUMI_FAIL]);
        $display("Input back-pressure seen on %0d cycles, %0d long output hold-offs, %0d errors",
                 in_stall_cycles, holds_done, error_count);
        if (error_count == 0)
        begin
            $display("[humidity_temp_frame_decoder_top] OK");
        end
        else
        begin
            $display("[humidity_temp_frame_decoder_top] ERROR");
        end
        $finish;
    end

endmodule
